FILE: sv/hda_pkg.sv
`timescale 1ns / 1ps

package hda_pkg;

   // Width of one element of a vector (signed fixed point).
   localparam int unsigned DATA_W = 32;
   // The divisor is 2^F plus a value below 2^32, which needs one more bit.
   localparam int unsigned DEN_W = DATA_W + 1;
   // Width of the running sum and of the distance (unsigned Q12.16).
   localparam int unsigned SUM_W = 28;

   // Status of the divider as the sequencer sees it.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: sv/hda_div.sv
`timescale 1ns / 1ps

module hda_div #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [hda_pkg::DATA_W-1:0]      dividend,
   input  logic [hda_pkg::DEN_W-1:0]       divisor,
   output logic [FRACTION_BITS-1:0]        quotient,
   output hda_pkg::div_status_type         status
);

   localparam int unsigned CNT_W = $clog2(FRACTION_BITS + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [hda_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [hda_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [FRACTION_BITS-1:0]    quo_ff, quo_in;
   logic [hda_pkg::DEN_W:0]     rem_shift;
   logic [hda_pkg::DEN_W:0]     rem_trial;

   // One restoring step per cycle: the dividend is always below the divisor,
   // so the partial remainder stays below the divisor and each step yields
   // one fraction bit of the quotient.
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_trial = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRACTION_BITS);
         rem_in  = {1'b0, dividend};
         den_in  = divisor;
      end else if (busy_ff) begin
         if (rem_trial[hda_pkg::DEN_W]) begin
            rem_in = rem_shift[hda_pkg::DEN_W-1:0];
            quo_in = {quo_ff[FRACTION_BITS-2:0], 1'b0};
         end else begin
            rem_in = rem_trial[hda_pkg::DEN_W-1:0];
            quo_in = {quo_ff[FRACTION_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with an exhausted step count");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without finishing a division");

endmodule

FILE: sv/hassanat_distance_accumulator.sv
`timescale 1ns / 1ps

// Hassanat distance accumulator. Each input item is one element pair (x, y) of
// two vectors in signed fixed point with FRACTION_BITS fraction bits, and the
// block adds |x-y| / (1 + max(x,y) - min(x,y,0)), truncated to FRACTION_BITS
// fraction bits, to a running sum. The item marked by req_tlast adds its term,
// then sends the sum as one result item (unsigned Q12.16, saturated at the
// maximum) and clears the sum. Each item goes through these steps in order: the
// block takes it, forms the divisor and starts the radix-2 divider, waits while
// the divider forms the quotient bits and until it reports that it is done, then
// adds the quotient into the sum; only then is it ready for the next item.
// A last item may wait further until the previous result item is taken.
module hassanat_distance_accumulator #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] x_value, [63:32] y_value
   input  logic        req_tlast,   // last_element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [27:0] distance, [31:28] zero
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SETUP = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_ACC   = 2'd3;

   localparam int unsigned DW = hda_pkg::DATA_W;
   localparam int unsigned SW = hda_pkg::SUM_W;

   logic [1:0]              state_ff, state_in;
   logic signed [DW-1:0]    x_ff, x_in;
   logic signed [DW-1:0]    y_ff, y_in;
   logic                    last_ff, last_in;
   logic [SW-1:0]           sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]           rsp_data_ff, rsp_data_in;

   logic                    x_gt;
   logic [DW:0]             d_xy;
   logic [DW:0]             d_yx;
   logic [DW-1:0]           diff;
   logic signed [DW-1:0]    hi;
   logic signed [DW-1:0]    lo;
   logic [hda_pkg::DEN_W-1:0] den;
   logic                    div_start;
   logic [FRACTION_BITS-1:0] quo;
   hda_pkg::div_status_type div_st;
   logic [SW:0]             sum_wide;
   logic [SW-1:0]           sum_sat;
   logic                    out_free;

   // Divisor setup from the stored pair. min(x, y, 0) is the smaller element
   // when that one is negative, else zero.
   assign x_gt = x_ff > y_ff;
   assign d_xy = {x_ff[DW-1], x_ff} - {y_ff[DW-1], y_ff};
   assign d_yx = {y_ff[DW-1], y_ff} - {x_ff[DW-1], x_ff};
   assign diff = x_gt ? d_xy[DW-1:0] : d_yx[DW-1:0];
   assign hi   = x_gt ? x_ff : y_ff;
   assign lo   = x_gt ? y_ff : x_ff;
   assign den  = (lo[DW-1] ? {1'b0, diff} : {1'b0, hi})
               + (hda_pkg::DEN_W'(1) << FRACTION_BITS);

   assign div_start = (state_ff == S_SETUP);

   hda_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff),
      .divisor  (den),
      .quotient (quo),
      .status   (div_st)
   );

   assign sum_wide = {1'b0, sum_ff} + {{(SW + 1 - FRACTION_BITS){1'b0}}, quo};
   assign sum_sat  = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata[DW-1:0];
               y_in     = req_tdata[2*DW-1:DW];
               last_in  = req_tlast;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_st.done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (!last_ff) begin
               sum_in   = sum_sat;
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_sat;
               sum_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - SW){1'b0}}, rsp_data_ff};

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_st.busy)
      else $error("input ready while the divider is still working");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_ACC && last_ff))
      else $error("result item raised without a last element");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> sum_ff == '0)
      else $error("running sum not cleared after a result item");

endmodule
